FILE: hdl/disparity_winner_select_subpixel_unit_assert.svh
// Assertion helpers shared by the RTL. All use aclk and aresetn of the
// including module.
`ifndef DISPARITY_WINNER_SELECT_SUBPIXEL_UNIT_ASSERT_SVH
`define DISPARITY_WINNER_SELECT_SUBPIXEL_UNIT_ASSERT_SVH

// same-cycle implication
`define DWSS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DWSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dwss_pkg.sv
package dwss_pkg;

    localparam int MAX_DISP_DEF = 128;

    localparam int COST_W = 16;
    localparam int DISP_W = 16;
    localparam int CONF_W = 8;
    localparam int CFG_W  = 8;
    localparam int D_W    = 19;   // 2*(c0 - 2*c1 + c2), signed
    localparam int DIFF_W = 17;   // c0 - c2, signed
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NUM_DISP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_DISP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SUBPIX   = 2'd2;

    localparam logic [CFG_W-1:0]        NUM_DISP_RST = 8'd64;
    localparam logic signed [CFG_W-1:0] MIN_DISP_RST = 8'sd0;
    localparam logic                    SUBPIX_RST   = 1'b1;

    localparam logic [COST_W-1:0] BEST_INIT  = 16'hFFFF;
    localparam logic [COST_W:0]   SECOND_INF = 17'h10000;
    localparam logic [CONF_W-1:0] CONF_MAX   = 8'd255;
    localparam logic [CONF_W-1:0] CONF_ZERO  = 8'd0;

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_CALC,
        ST_MUL,
        ST_NUM,
        ST_DSTART,
        ST_DIVD,
        ST_CONF,
        ST_DIVC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: hdl/dwss_divider.sv
module dwss_divider #(
    parameter int DVD_W = 34,
    parameter int DVS_W = 19
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DVD_W-1:0]      dividend,
    input  logic [DVS_W-1:0]      divisor,
    output logic [DVD_W-1:0]      quotient,
    output dwss_pkg::div_status_t status
);
    import dwss_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0] rem_shift;
    logic [DVS_W:0] rem_sub;
    logic           fits;

    // restoring step, one quotient bit per cycle
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DVD_W-1]};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        fits      = (rem_shift >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? rem_sub[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign status   = '{busy: busy_reg, done: done_reg};

endmodule

FILE: hdl/disparity_winner_select_subpixel_unit.sv
// Winner-take-all disparity select with parabolic subpixel refinement.
// Input channel (s_valid/s_ready/s_cost): one aggregated cost per transaction,
// unsigned Q8.8, one per candidate disparity, in disparity order. A pixel is
// num_disparities transactions (clamped to 1..MAX_DISPARITIES).
// Result channel (m_valid/m_ready/m_disparity/m_confidence): one transaction
// per pixel, disparity in signed Q12.4 and an 8-bit uniqueness confidence.
// Config port (cfg_we/cfg_index/cfg_wdata): 0 num_disparities,
// 1 min_disparity, 2 subpixel_enable; other indexes are ignored. Write only
// while idle.
// Timing: costs are taken one per cycle while collecting. After the last cost
// the block drops s_ready and runs a finish sequence: three store reads,
// d/numerator setup, a shared radix-2 divider for the subpixel quotient and
// again for the confidence ratio. The subpixel division is skipped without
// refinement or when d is zero, and the ratio division is skipped when the
// confidence is trivial (best cost zero or no runner-up).
// Reset: config returns to 64 / 0 / 1, the pixel tracker clears, no result
// is pending. The cost store is not cleared; only entries of the current
// pixel are read.
// Stall: a finished result sits in the output register until m_ready; the
// next result waits in the finish state until that register frees.

`include "disparity_winner_select_subpixel_unit_assert.svh"

module disparity_winner_select_subpixel_unit #(
    parameter int MAX_DISPARITIES = dwss_pkg::MAX_DISP_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [dwss_pkg::COST_W-1:0]           s_cost,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [dwss_pkg::DISP_W-1:0]    m_disparity,
    output logic [dwss_pkg::CONF_W-1:0]           m_confidence,

    input  logic                                  cfg_we,
    input  logic [dwss_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dwss_pkg::CFG_W-1:0]            cfg_wdata
);
    import dwss_pkg::*;

    localparam int IDX_W = (MAX_DISPARITIES > 2) ? $clog2(MAX_DISPARITIES) : 1;
    // count compare width: holds MAX_DISPARITIES and any register value
    localparam int EC_W  = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
    // min_disparity + best_index
    localparam int S_W   = (IDX_W > 7) ? IDX_W + 2 : CFG_W + 1;
    localparam int P_W   = S_W + D_W;
    // 16*(s*d + c0 - c2)
    localparam int NUM_W = P_W + 5;

    localparam logic signed [NUM_W:0] SAT_HI = (NUM_W+1)'(32767);
    localparam logic signed [NUM_W:0] SAT_LO = -(NUM_W+1)'(32768);

    function automatic logic signed [DISP_W-1:0] sat_disp(input logic signed [NUM_W:0] v);
        logic signed [DISP_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[DISP_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[DISP_W-1:0];
        end else begin
            r = v[DISP_W-1:0];
        end
        return r;
    endfunction

    // ---------------- config registers ----------------
    logic [CFG_W-1:0]        num_disp_reg;
    logic signed [CFG_W-1:0] min_disp_reg;
    logic                    subpix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_disp_reg <= NUM_DISP_RST;
            min_disp_reg <= MIN_DISP_RST;
            subpix_reg   <= SUBPIX_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IDX_NUM_DISP: num_disp_reg <= cfg_wdata;
                CFG_IDX_MIN_DISP: min_disp_reg <= $signed(cfg_wdata);
                CFG_IDX_SUBPIX:   subpix_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---------------- state ----------------
    state_t state_reg, state_next;

    logic [IDX_W-1:0]  pos_reg;
    logic [COST_W-1:0] best_reg, best_next;
    logic [COST_W:0]   sec_reg, sec_next;
    logic [IDX_W-1:0]  bi_reg, bi_next;

    logic signed [S_W-1:0]    s_reg;
    logic [COST_W-1:0]        c0_reg, c1_reg, rd_data_reg;
    logic signed [D_W-1:0]    d_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [P_W-1:0]    prod_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic                     neg_reg;
    logic signed [DISP_W-1:0] disp_reg;
    logic [CONF_W-1:0]        conf_reg;

    logic                     m_valid_reg;
    logic signed [DISP_W-1:0] m_disp_reg;
    logic [CONF_W-1:0]        m_conf_reg;

    logic [COST_W-1:0] cost_store [MAX_DISPARITIES];

    // ---------------- collect path ----------------
    logic                     accept;
    logic [EC_W-1:0]          eff_cnt;
    logic                     last_cost;
    logic                     refine_n;
    logic signed [S_W-1:0]    s_n;
    logic signed [NUM_W:0]    plain_disp;

    always_comb begin
        accept = s_valid && s_ready;

        priority if (num_disp_reg == '0) begin
            eff_cnt = EC_W'(1);
        end else if (EC_W'(num_disp_reg) > EC_W'(MAX_DISPARITIES)) begin
            eff_cnt = EC_W'(MAX_DISPARITIES);
        end else begin
            eff_cnt = EC_W'(num_disp_reg);
        end
        last_cost = (EC_W'(pos_reg) + EC_W'(1)) >= eff_cnt;

        // first strict minimum and runner-up
        best_next = best_reg;
        sec_next  = sec_reg;
        bi_next   = bi_reg;
        priority if (pos_reg == '0) begin
            best_next = s_cost;
            sec_next  = SECOND_INF;
            bi_next   = '0;
        end else if (s_cost < best_reg) begin
            sec_next  = {1'b0, best_reg};
            best_next = s_cost;
            bi_next   = pos_reg;
        end else if ({1'b0, s_cost} < sec_reg) begin
            sec_next  = {1'b0, s_cost};
        end

        refine_n = subpix_reg && (bi_next != '0)
                   && ((EC_W'(bi_next) + EC_W'(1)) < eff_cnt);
        s_n        = S_W'(min_disp_reg) + S_W'($signed({1'b0, bi_next}));
        plain_disp = (NUM_W+1)'(s_n) <<< 4;
    end

    // ---------------- sequencer ----------------
    div_status_t          div_st;
    logic                 div_start;
    logic [NUM_W-1:0]     div_dvd;
    logic [D_W-1:0]       div_dvs;
    logic [NUM_W-1:0]     div_quo;
    logic [IDX_W-1:0]     rd_addr;
    logic                 out_load;
    logic [COST_W-1:0]    conf_diff;
    logic                 conf_trivial;

    always_comb begin
        conf_trivial = (best_reg == '0) || (sec_reg == SECOND_INF);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT: begin
                if (accept && last_cost) begin
                    state_next = refine_n ? ST_RD0 : ST_CONF;
                end
            end
            ST_RD0:    state_next = ST_RD1;
            ST_RD1:    state_next = ST_RD2;
            ST_RD2:    state_next = ST_CALC;
            ST_CALC:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_NUM;
            ST_NUM:    state_next = ST_DSTART;
            ST_DSTART: state_next = (d_reg == '0) ? ST_CONF : ST_DIVD;
            ST_DIVD: begin
                if (div_st.done) begin
                    state_next = ST_CONF;
                end
            end
            ST_CONF:   state_next = conf_trivial ? ST_OUT : ST_DIVC;
            ST_DIVC: begin
                if (div_st.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_COLLECT;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        rd_addr   = bi_reg;
        out_load  = 1'b0;
        conf_diff = sec_reg[COST_W-1:0] - best_reg;
        unique case (state_reg)
            ST_COLLECT: s_ready = 1'b1;
            ST_RD0:     rd_addr = bi_reg - IDX_W'(1);
            ST_RD1:     rd_addr = bi_reg;
            ST_RD2:     rd_addr = bi_reg + IDX_W'(1);
            ST_DSTART: begin
                div_start = (d_reg != '0);
                div_dvd   = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
                div_dvs   = d_reg[D_W-1] ? D_W'(-d_reg) : D_W'(d_reg);
            end
            ST_CONF: begin
                // 255*(second - best) / second
                div_start = !conf_trivial;
                div_dvd   = NUM_W'({conf_diff, 8'h00} - {8'h00, conf_diff});
                div_dvs   = D_W'(sec_reg[COST_W-1:0]);
            end
            ST_OUT:     out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    dwss_divider #(
        .DVD_W (NUM_W),
        .DVS_W (D_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_quo),
        .status   (div_st)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_COLLECT;
            pos_reg     <= '0;
            best_reg    <= BEST_INIT;
            sec_reg     <= SECOND_INF;
            bi_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                pos_reg  <= last_cost ? '0 : pos_reg + IDX_W'(1);
                best_reg <= best_next;
                sec_reg  <= sec_next;
                bi_reg   <= bi_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- cost store ----------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            cost_store[pos_reg] <= s_cost;
        end
        rd_data_reg <= cost_store[rd_addr];
    end

    // ---------------- datapath ----------------
    always_ff @(posedge aclk) begin
        if (accept && last_cost) begin
            s_reg      <= s_n;
            disp_reg   <= sat_disp(plain_disp);
        end
        if (state_reg == ST_RD1) begin
            c0_reg <= rd_data_reg;
        end
        if (state_reg == ST_RD2) begin
            c1_reg <= rd_data_reg;
        end
        if (state_reg == ST_CALC) begin
            // rd_data_reg holds c2 here
            d_reg <= ($signed({3'b000, c0_reg}) - $signed({2'b00, c1_reg, 1'b0})
                      + $signed({3'b000, rd_data_reg})) <<< 1;
            diff_reg <= $signed({1'b0, c0_reg}) - $signed({1'b0, rd_data_reg});
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= s_reg * d_reg;
        end
        if (state_reg == ST_NUM) begin
            num_reg <= (NUM_W'(prod_reg) + NUM_W'(diff_reg)) <<< 4;
        end
        if (state_reg == ST_DSTART) begin
            neg_reg <= num_reg[NUM_W-1] ^ d_reg[D_W-1];
        end
        if (state_reg == ST_DIVD && div_st.done) begin
            disp_reg <= sat_disp(neg_reg ? -$signed({1'b0, div_quo})
                                         : $signed({1'b0, div_quo}));
        end
        if (state_reg == ST_CONF) begin
            conf_reg <= (best_reg == '0) ? CONF_ZERO : CONF_MAX;
        end
        if (state_reg == ST_DIVC && div_st.done) begin
            conf_reg <= div_quo[CONF_W-1:0];
        end
        if (out_load) begin
            m_disp_reg <= disp_reg;
            m_conf_reg <= conf_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_disparity  = m_disp_reg;
    assign m_confidence = m_conf_reg;

    // ---------------- assertions ----------------
    `DWSS_ASSERT_IMPLIES(a_div_in_div_state, div_st.busy || div_st.done,
        state_reg == ST_DIVD || state_reg == ST_DIVC, "divider active outside divide states")
    `DWSS_ASSERT_NEXT(a_out_only_from_out, state_reg != ST_OUT && !m_valid_reg,
        !m_valid_reg, "result appeared without passing the output state")
    `DWSS_ASSERT_IMPLIES(a_pos_clear_in_finish, state_reg != ST_COLLECT,
        pos_reg == '0, "cost position not cleared during finish sequence")

endmodule
